[hw/rtl/skfus_pkg.sv]
// Shared types, constants and the mixing sign table of the knob sensor fusion block.
package skfus_pkg;

	localparam int NCH = 6;

	typedef logic [11:0] sample_t;
	typedef logic signed [12:0] diff_t;
	typedef logic signed [14:0] calsum_t;
	typedef logic signed [15:0] acc_t;
	typedef logic signed [14:0] axis_t;
	typedef logic [13:0] mag_t;
	typedef logic [16:0] total_t;
	typedef logic [13:0] dz_t;
	typedef logic [1:0] cfg_idx_t;

	localparam sample_t CENTER_BASE = 12'd2000;

	// Division by seven as multiplication by ceil(2^19 / 7), exact for 16-bit dividends.
	localparam logic [16:0] DIV7_RECIP = 17'd74899;
	localparam int DIV7_SHIFT = 19;

	localparam cfg_idx_t CFG_SENSOR_DZ = 2'd0;
	localparam cfg_idx_t CFG_TRANS_DZ = 2'd1;
	localparam cfg_idx_t CFG_ROT_DZ = 2'd2;

	// Bit j of row i is set where channel j enters axis i with a negative sign.
	localparam logic [NCH-1:0] MIX_NEG [NCH] = '{
		6'b101000,
		6'b010010,
		6'b111010,
		6'b110010,
		6'b000111,
		6'b010011
	};

	typedef struct packed {
		logic adv;
		logic cal;
		logic cal_wrap;
	} chan_ctl_t;

endpackage

[hw/rtl/six_axis_knob_sensor_fusion.sv]
// Top level of the six-axis knob sensor fusion block: lanes, merging stage and handshakes.
//
//  Channel  | Signals                                        | Direction
//  frame    | frame_valid, frame_stall, kind, sample_0..5    | in (stall out)
//  axes     | axes_valid, axes_stall, move_x..z, turn_x..z   | out (stall in)
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | in (ready out)
//
// A frame can be accepted every cycle unless stalled; an all-zero measurement result is dropped.
// A calibration item updates the sums, and every fourth one the centers, at its accepting edge.
// Reset sets centers to 2000, clears sums and counter, and sets deadzones to 22, 65 and 110.
// All stages advance together whenever the output register is empty or being taken.
module six_axis_knob_sensor_fusion import skfus_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic frame_valid,
	output logic frame_stall,
	input logic kind,
	input sample_t sample_0,
	input sample_t sample_1,
	input sample_t sample_2,
	input sample_t sample_3,
	input sample_t sample_4,
	input sample_t sample_5,
	output logic axes_valid,
	input logic axes_stall,
	output axis_t move_x,
	output axis_t move_y,
	output axis_t move_z,
	output axis_t turn_x,
	output axis_t turn_y,
	output axis_t turn_z,
	input logic cfg_valid,
	output logic cfg_ready,
	input cfg_idx_t cfg_index,
	input logic [13:0] cfg_data
);

	logic adv;
	logic accept;
	chan_ctl_t ctl;
	logic [1:0] cal_cnt_q;
	sample_t sensor_dz_q;
	dz_t trans_dz_q;
	dz_t rot_dz_q;
	sample_t samples [NCH];
	diff_t d_s1 [NCH];
	axis_t m_s2 [NCH];
	mag_t mag_s2 [NCH];
	axis_t m_s3 [NCH];
	mag_t mag_s3 [NCH];
	total_t total_c;
	total_t total_s3;
	axis_t res_s5 [NCH];
	logic [NCH-1:0] nz;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic v_s5;

	assign adv = !v_s5 || !axes_stall;
	assign frame_stall = !adv;
	assign accept = frame_valid && adv;
	assign cfg_ready = 1'b1;
	assign axes_valid = v_s5;

	assign ctl.adv = adv;
	assign ctl.cal = accept && !kind;
	assign ctl.cal_wrap = (cal_cnt_q == 2'd3);

	assign samples[0] = sample_0;
	assign samples[1] = sample_1;
	assign samples[2] = sample_2;
	assign samples[3] = sample_3;
	assign samples[4] = sample_4;
	assign samples[5] = sample_5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_dz_q <= 12'd22;
			trans_dz_q <= 14'd65;
			rot_dz_q <= 14'd110;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SENSOR_DZ: sensor_dz_q <= cfg_data[11:0];
				CFG_TRANS_DZ: trans_dz_q <= cfg_data;
				CFG_ROT_DZ: rot_dz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_cnt_q <= '0;
		end else if (ctl.cal) begin
			cal_cnt_q <= cal_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept && kind;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && (nz != '0);
		end
	end

	for (genvar i = 0; i < NCH; i++) begin : g_chan
		skfus_chan u_chan (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.sample(samples[i]),
			.sensor_dz(sensor_dz_q),
			.d_s1(d_s1[i])
		);
	end

	for (genvar i = 0; i < NCH; i++) begin : g_mix
		skfus_mix u_mix (
			.clk(clk),
			.adv(adv),
			.d(d_s1),
			.neg(MIX_NEG[i]),
			.m_s2(m_s2[i]),
			.mag_s2(mag_s2[i])
		);
	end

	// The merging stage adds up the six axis magnitudes.
	always_comb begin
		total_c = '0;
		for (int i = 0; i < NCH; i++) begin
			total_c = total_c + total_t'(mag_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			total_s3 <= total_c;
			m_s3 <= m_s2;
			mag_s3 <= mag_s2;
		end
	end

	for (genvar i = 0; i < NCH; i++) begin : g_supp
		skfus_supp u_supp (
			.clk(clk),
			.adv(adv),
			.total(total_s3),
			.m(m_s3[i]),
			.mag(mag_s3[i]),
			.dz((i < 3) ? trans_dz_q : rot_dz_q),
			.res_s5(res_s5[i]),
			.nz(nz[i])
		);
	end

	assign move_x = res_s5[0];
	assign move_y = res_s5[1];
	assign move_z = res_s5[2];
	assign turn_x = res_s5[3];
	assign turn_y = res_s5[4];
	assign turn_z = res_s5[5];

	a_out_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		axes_valid |-> (move_x != '0 || move_y != '0 || move_z != '0 ||
			turn_x != '0 || turn_y != '0 || turn_z != '0))
		else $error("result item with all axes zero");

	a_cal_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cal && cal_cnt_q == 2'd3) |=> (cal_cnt_q == 2'd0))
		else $error("calibration counter did not wrap after fourth frame");

	a_s1_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(frame_valid && !frame_stall && kind))
		else $error("measurement stage entered without an accepted measurement item");

	a_no_cal_in_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !kind) |=> !v_s1)
		else $error("calibration item entered the measurement pipeline");

endmodule

[hw/rtl/skfus_chan.sv]
// Channel lane: calibration accumulator, center register, centering and deadzone shrink.
module skfus_chan import skfus_pkg::*; (
	input logic clk,
	input logic arst_n,
	input chan_ctl_t ctl,
	input sample_t sample,
	input sample_t sensor_dz,
	output diff_t d_s1
);

	calsum_t sum_q;
	calsum_t sum_nxt;
	calsum_t sum_rnd;
	sample_t center_q;
	sample_t center_new;
	diff_t diff;
	diff_t lim;
	diff_t shrunk;

	always_comb begin
		sum_nxt = sum_q + $signed({3'b000, sample}) - $signed({3'b000, CENTER_BASE});
		sum_rnd = sum_nxt + (sum_nxt[14] ? 15'sd3 : 15'sd0);
		center_new = sum_rnd[13:2] + CENTER_BASE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			center_q <= CENTER_BASE;
		end else if (ctl.cal) begin
			if (ctl.cal_wrap) begin
				sum_q <= '0;
				center_q <= center_new;
			end else begin
				sum_q <= sum_nxt;
			end
		end
	end

	always_comb begin
		diff = $signed({1'b0, center_q}) - $signed({1'b0, sample});
		lim = $signed({1'b0, sensor_dz});
		shrunk = '0;
		if (!diff[12]) begin
			if (diff > lim) begin
				shrunk = diff - lim;
			end
		end else begin
			if (diff < -lim) begin
				shrunk = diff + lim;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			d_s1 <= shrunk;
		end
	end

endmodule

[hw/rtl/skfus_mix.sv]
// Axis lane of the sign matrix: signed sum of the six channels, halved toward zero.
module skfus_mix import skfus_pkg::*; (
	input logic clk,
	input logic adv,
	input diff_t d [NCH],
	input logic [NCH-1:0] neg,
	output axis_t m_s2,
	output mag_t mag_s2
);

	acc_t acc;
	acc_t acc_h;
	axis_t m;
	axis_t m_neg;

	always_comb begin
		acc = '0;
		for (int j = 0; j < NCH; j++) begin
			if (neg[j]) begin
				acc = acc - acc_t'(d[j]);
			end else begin
				acc = acc + acc_t'(d[j]);
			end
		end
		acc_h = acc + acc_t'({15'b0, acc[15]});
		m = acc_h[15:1];
		m_neg = -m;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2 <= m;
			mag_s2 <= m[14] ? m_neg[13:0] : m[13:0];
		end
	end

endmodule

[hw/rtl/skfus_supp.sv]
// Axis lane of the cross suppression: other magnitudes over seven plus deadzone, then shrink.
module skfus_supp import skfus_pkg::*; (
	input logic clk,
	input logic adv,
	input total_t total,
	input axis_t m,
	input mag_t mag,
	input dz_t dz,
	output axis_t res_s5,
	output logic nz
);

	logic [15:0] others;
	logic [32:0] prod;
	mag_t q_s4;
	axis_t m_s4;
	mag_t mag_s4;
	logic [14:0] thr;
	logic signed [15:0] mw;
	axis_t res;

	always_comb begin
		others = 16'(total - {3'b000, mag});
		prod = {17'b0, others} * {16'b0, DIV7_RECIP};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s4 <= prod[DIV7_SHIFT+13:DIV7_SHIFT];
			m_s4 <= m;
			mag_s4 <= mag;
		end
	end

	always_comb begin
		thr = {1'b0, q_s4} + {1'b0, dz};
		if (m_s4[14]) begin
			mw = $signed({m_s4[14], m_s4}) + $signed({1'b0, thr});
		end else begin
			mw = $signed({m_s4[14], m_s4}) - $signed({1'b0, thr});
		end
		res = ({1'b0, mag_s4} > thr) ? mw[14:0] : '0;
		nz = (res != '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s5 <= res;
		end
	end

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the six-axis knob sensor fusion block.
`timescale 1ns / 1ps

module tb_top;
	import skfus_pkg::*;

	localparam logic CAL_FRAME = 1'b0;
	localparam logic MEAS_FRAME = 1'b1;
	localparam cfg_idx_t CFG_SPARE = 2'd3;
	localparam int CENTER_MID = 2000;
	localparam int SUPPRESS_DIV = 7;
	localparam int CAL_FRAMES = 4;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 200;

	// Bit j of row i is set where channel j enters axis i negated.
	localparam logic [0:NCH-1][0:NCH-1] MIX_FLIP = {
		6'b000101,
		6'b010010,
		6'b010111,
		6'b010011,
		6'b111000,
		6'b110010
	};

	typedef axis_t [0:NCH-1] axes_t;

	typedef struct packed {
		logic kind;
		sample_t [0:NCH-1] smp;
	} frame_t;

	typedef struct packed {
		logic kind;
		sample_t [0:NCH-1] smp;
		logic fixed;
		logic silent;
		axes_t ax;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic frame_valid;
	logic frame_stall;
	logic kind;
	sample_t sample_0, sample_1, sample_2, sample_3, sample_4, sample_5;
	logic axes_valid;
	logic axes_stall;
	axis_t move_x, move_y, move_z, turn_x, turn_y, turn_z;
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	logic [13:0] cfg_data;

	int center [NCH];
	int cal_sum [NCH];
	int cal_count;
	int sens_dz;
	int move_dz;
	int turn_dz;

	axes_t axes_q [$];
	directed_row_t directed_rows [$];
	string AXIS_NAME [NCH] = '{"move_x", "move_y", "move_z", "turn_x", "turn_y", "turn_z"};

	bit send_idle;
	bit recv_idle;
	int errors;
	int frames_sent;
	int cal_frames;
	int results_checked;
	int cfg_writes;

	six_axis_knob_sensor_fusion uut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.kind(kind),
		.sample_0(sample_0),
		.sample_1(sample_1),
		.sample_2(sample_2),
		.sample_3(sample_3),
		.sample_4(sample_4),
		.sample_5(sample_5),
		.axes_valid(axes_valid),
		.axes_stall(axes_stall),
		.move_x(move_x),
		.move_y(move_y),
		.move_z(move_z),
		.turn_x(turn_x),
		.turn_y(turn_y),
		.turn_z(turn_z),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Timed out with %0d axis items still pending.", axes_q.size());
		$display("six_axis_knob_sensor_fusion regression: fail");
		$finish;
	end

	task automatic note_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int shrink_toward_zero(input int v, input int t);
		if (v > 0) begin
			return (v > t) ? v - t : 0;
		end
		return (v < -t) ? v + t : 0;
	endfunction

	function automatic int magnitude(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic void reset_fusion_state();
		for (int i = 0; i < NCH; i++) begin
			center[i] = CENTER_MID;
			cal_sum[i] = 0;
		end
		cal_count = 0;
		sens_dz = 22;
		move_dz = 65;
		turn_dz = 110;
	endfunction

	// Updates the calibration state and returns whether the frame yields an axis item.
	function automatic bit predict_axes(input frame_t f, output axes_t r);
		int d [NCH];
		int m [NCH];
		int acc;
		int total;
		int t;
		bit any;
		r = '0;
		if (f.kind == CAL_FRAME) begin
			for (int i = 0; i < NCH; i++) begin
				cal_sum[i] += int'(f.smp[i]) - CENTER_MID;
			end
			cal_count = (cal_count + 1) % CAL_FRAMES;
			if (cal_count == 0) begin
				for (int i = 0; i < NCH; i++) begin
					center[i] = cal_sum[i] / CAL_FRAMES + CENTER_MID;
					cal_sum[i] = 0;
				end
			end
			return 1'b0;
		end
		for (int i = 0; i < NCH; i++) begin
			d[i] = shrink_toward_zero(center[i] - int'(f.smp[i]), sens_dz);
		end
		total = 0;
		for (int i = 0; i < NCH; i++) begin
			acc = 0;
			for (int j = 0; j < NCH; j++) begin
				acc += MIX_FLIP[i][j] ? -d[j] : d[j];
			end
			m[i] = acc / 2;
			total += magnitude(m[i]);
		end
		any = 1'b0;
		for (int i = 0; i < NCH; i++) begin
			t = (total - magnitude(m[i])) / SUPPRESS_DIV + ((i < 3) ? move_dz : turn_dz);
			m[i] = shrink_toward_zero(m[i], t);
			if (m[i] != 0) begin
				any = 1'b1;
			end
			r[i] = axis_t'(m[i]);
		end
		return any;
	endfunction

	function automatic void add_row(input logic k, input sample_t [0:NCH-1] s,
			input logic fixed, input logic silent, input axes_t ax);
		directed_row_t r;
		r.kind = k;
		r.smp = s;
		r.fixed = fixed;
		r.silent = silent;
		r.ax = ax;
		directed_rows.push_back(r);
	endfunction

	// Samples lie around the centers (2000 for calibration) at several spreads so deadzones bite.
	function automatic frame_t random_frame();
		frame_t f;
		int style;
		int spread;
		int base;
		int v;
		f.kind = ($urandom_range(0, 4) == 0) ? CAL_FRAME : MEAS_FRAME;
		style = $urandom_range(0, 3);
		for (int i = 0; i < NCH; i++) begin
			base = (f.kind == CAL_FRAME) ? CENTER_MID : center[i];
			case (style)
				0: spread = 5000;
				1: spread = (f.kind == CAL_FRAME) ? 150 : 400;
				2: spread = sens_dz + 80;
				default: spread = 40;
			endcase
			if (spread >= 5000) begin
				v = $urandom_range(0, 4095);
			end else begin
				v = base + int'($urandom_range(0, 2 * spread)) - spread;
			end
			if (v < 0) begin
				v = 0;
			end
			if (v > 4095) begin
				v = 4095;
			end
			f.smp[i] = sample_t'(v);
		end
		return f;
	endfunction

	task automatic send_frame(input frame_t f);
		int n;
		logic st;
		n = send_idle ? $urandom_range(0, 13) : 0;
		if (n > 0) begin
			frame_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		frame_valid <= 1'b1;
		kind <= f.kind;
		sample_0 <= f.smp[0];
		sample_1 <= f.smp[1];
		sample_2 <= f.smp[2];
		sample_3 <= f.smp[3];
		sample_4 <= f.smp[4];
		sample_5 <= f.smp[5];
		do begin
			@(negedge clk);
			st = frame_stall;
			@(posedge clk);
		end while (st !== 1'b0);
		frames_sent++;
		if (f.kind == CAL_FRAME) begin
			cal_frames++;
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [13:0] data);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (rdy !== 1'b1);
		case (idx)
			CFG_SENSOR_DZ: sens_dz = int'(data[11:0]);
			CFG_TRANS_DZ: move_dz = int'(data);
			CFG_ROT_DZ: turn_dz = int'(data);
			default: ;
		endcase
		cfg_writes++;
	endtask

	// The pipeline is five stages deep and frames without a result leave no trace in the queue.
	task automatic settle();
		int waited;
		waited = 0;
		frame_valid <= 1'b0;
		while (axes_q.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [13:0] pick_deadzone(input int top, input int typical);
		case ($urandom_range(0, 5))
			0: return 14'd0;
			1: return 14'(top);
			default: return 14'($urandom_range(0, typical));
		endcase
	endfunction

	initial begin : axes_sink
		int n;
		logic seen;
		axes_t got;
		axes_t want;
		axes_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = recv_idle ? $urandom_range(0, 13) : 0;
			if (n > 0) begin
				axes_stall <= 1'b1;
				repeat (n) @(posedge clk);
				axes_stall <= 1'b0;
			end
			do begin
				@(negedge clk);
				seen = axes_valid;
				got = {move_x, move_y, move_z, turn_x, turn_y, turn_z};
				@(posedge clk);
			end while (seen !== 1'b1);
			if (axes_q.size() == 0) begin
				note_mismatch($sformatf("axis item with no frame pending: %p", got));
			end else begin
				want = axes_q.pop_front();
				for (int i = 0; i < NCH; i++) begin
					if (got[i] !== want[i]) begin
						note_mismatch($sformatf("%s got %0d, want %0d", AXIS_NAME[i],
							got[i], want[i]));
					end
				end
				results_checked++;
			end
		end
	end

	initial begin : frame_source
		frame_t f;
		axes_t ax;
		sample_t [0:NCH-1] s;
		logic [13:0] dz;
		arst_n = 1'b0;
		frame_valid = 1'b0;
		kind = CAL_FRAME;
		sample_0 = '0;
		sample_1 = '0;
		sample_2 = '0;
		sample_3 = '0;
		sample_4 = '0;
		sample_5 = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SENSOR_DZ;
		cfg_data = '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		reset_fusion_state();

		add_row(MEAS_FRAME, {NCH{12'd2000}}, 1'b1, 1'b1, '0);
		add_row(MEAS_FRAME, {NCH{12'd0}}, 1'b1, 1'b0, {axis_t'(1348), axis_t'(1348),
			axis_t'(-1348), axis_t'(0), axis_t'(0), axis_t'(0)});
		add_row(MEAS_FRAME, {NCH{12'd4095}}, 1'b1, 1'b0, {axis_t'(-1416), axis_t'(-1416),
			axis_t'(1416), axis_t'(0), axis_t'(0), axis_t'(0)});
		add_row(MEAS_FRAME, {NCH{12'd2022}}, 1'b1, 1'b1, '0);
		add_row(MEAS_FRAME, {NCH{12'd1978}}, 1'b1, 1'b1, '0);
		for (int j = 0; j < NCH; j++) begin
			s = {NCH{12'd2000}};
			s[j] = (j % 2 == 1) ? 12'd4095 : 12'd0;
			add_row(MEAS_FRAME, s, 1'b0, 1'b0, '0);
		end
		repeat (CAL_FRAMES) add_row(CAL_FRAME, {NCH{12'd0}}, 1'b1, 1'b1, '0);
		add_row(MEAS_FRAME, {NCH{12'd4095}}, 1'b0, 1'b0, '0);
		repeat (CAL_FRAMES) add_row(CAL_FRAME, {NCH{12'd4095}}, 1'b1, 1'b1, '0);
		add_row(MEAS_FRAME, {NCH{12'd0}}, 1'b0, 1'b0, '0);
		repeat (CAL_FRAMES) add_row(CAL_FRAME, {12'd2003, 12'd1997, 12'd2100, 12'd1900,
			12'd2000, 12'd2050}, 1'b1, 1'b1, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			f.kind = directed_rows[r].kind;
			f.smp = directed_rows[r].smp;
			send_frame(f);
			if (predict_axes(f, ax) && !directed_rows[r].fixed) begin
				axes_q.push_back(ax);
			end else if (directed_rows[r].fixed && !directed_rows[r].silent) begin
				axes_q.push_back(directed_rows[r].ax);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			send_idle = !(phase % 3 == 1 || phase == PHASES - 1);
			recv_idle = !(phase % 3 == 2 || phase == PHASES - 1);
			if (phase == 1) begin
				write_reg(CFG_SENSOR_DZ, 14'd0);
				write_reg(CFG_TRANS_DZ, 14'd0);
				write_reg(CFG_ROT_DZ, 14'd0);
				cfg_valid <= 1'b0;
			end else if (phase == 2) begin
				write_reg(CFG_SENSOR_DZ, 14'h3FFF);
				write_reg(CFG_TRANS_DZ, 14'h3FFF);
				write_reg(CFG_ROT_DZ, 14'h3FFF);
				write_reg(CFG_SPARE, 14'h0000);
				cfg_valid <= 1'b0;
			end else if (phase > 2) begin
				dz = pick_deadzone(4095, 120);
				write_reg(CFG_SENSOR_DZ, {2'($urandom), dz[11:0]});
				write_reg(CFG_SPARE, 14'($urandom));
				write_reg(CFG_TRANS_DZ, pick_deadzone(16383, 300));
				write_reg(CFG_ROT_DZ, pick_deadzone(16383, 300));
				cfg_valid <= 1'b0;
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				f = random_frame();
				send_frame(f);
				if (predict_axes(f, ax)) begin
					axes_q.push_back(ax);
				end
			end
		end

		settle();
		if (axes_q.size() != 0) begin
			note_mismatch($sformatf("%0d expected axis items never arrived", axes_q.size()));
		end
		$display("Sent %0d frames (%0d calibration) across %0d deadzone settings with %0d writes.",
			frames_sent, cal_frames, PHASES, cfg_writes);
		$display("Checked %0d axis items field by field; %0d mismatches.",
			results_checked, errors);
		if (errors == 0) begin
			$display("six_axis_knob_sensor_fusion regression: pass");
		end else begin
			$display("six_axis_knob_sensor_fusion regression: fail");
		end
		$finish;
	end

endmodule

[six_axis_knob_sensor_fusion.f]
hw/rtl/skfus_pkg.sv
hw/rtl/skfus_chan.sv
hw/rtl/skfus_mix.sv
hw/rtl/skfus_supp.sv
hw/rtl/six_axis_knob_sensor_fusion.sv
dv/tb_top.sv
